@@ src/integer_to_radix_string_assert.svh @@
// Assertion shorthands for the RTL. Each expects clk and rst_n in scope.
`ifndef INTEGER_TO_RADIX_STRING_ASSERT_SVH
`define INTEGER_TO_RADIX_STRING_ASSERT_SVH

// Same-cycle implication.
`define ITRS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ITRS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/itrs_pkg.sv @@
`default_nettype none
package itrs_pkg;

  localparam int DIGIT_DEPTH = 64;
  localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);
  localparam int NUM_W       = 64;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int REM_W       = DIGIT_W + 1;
  localparam int CHAR_W      = 8;
  localparam int STEP_W      = $clog2(NUM_W);
  localparam int IN_TDATA_W  = ((NUM_W + RADIX_W + 7) / 8) * 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
  localparam logic [DIGIT_W-1:0] DEC_BASE  = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPA   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_PFX0,
    S_PFXX,
    S_SIGN,
    S_RDREQ,
    S_DIGIT
  } state_t;

  // Map one digit to its ASCII character: 0..9 then A..Z.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W - DIGIT_W){1'b0}}, d};
    if (d < DEC_BASE) begin
      return CHAR_ZERO + d_ext;
    end
    return CHAR_UPA + d_ext - {{(CHAR_W - DIGIT_W){1'b0}}, DEC_BASE};
  endfunction

endpackage
`default_nettype wire

@@ src/integer_to_radix_string.sv @@
// Signed 64-bit integer to ASCII text in any base from 2 to 36.
// Input channel in_*: one item carries number (tdata[63:0], two's complement)
// and radix (tdata[69:64]). Output channel out_*: one ASCII character per
// item in tdata, most significant first; tlast marks the final character of
// a conversion and tuser flags an error (bad radix or the most negative
// value), which comes as a single NUL character with tlast set.
// Base 16 texts open with "0x", placed before any '-' sign; zero gives "0".
// In sequence, an item is first accepted and then checked; each digit then
// comes from the bit-serial divider (64 quotient bits) and its remainder is
// written into the digit memory; each emitted digit takes a memory read, then
// an output load, and a prefix or sign character takes only an output load.
// One conversion is in flight at a time; in_tready is high only when idle.
// The output register decouples the sides: while the receiver stalls the
// current character holds and the sequencer waits. Reset (rst_n low,
// synchronous) drops any conversion and clears the output valid; the digit
// memory needs no clearing pass since each entry is written before it is read.
`default_nettype none
`include "integer_to_radix_string_assert.svh"
module integer_to_radix_string import itrs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // [63:0] number, [69:64] radix, [71:70] zero
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [CHAR_W-1:0]     out_tdata,  // [7:0] character
  output      logic                  out_tlast,
  output      logic                  out_tuser   // [0] error
);

  state_t state_r, state_nxt;

  // Operands held for the whole conversion
  logic [NUM_W-1:0]   number_r;
  logic [RADIX_W-1:0] radix_r;

  // Digit bookkeeping
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic              out_err_r;

  // Datapath controls
  logic              out_load;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              out_err;
  logic              div_start;
  logic [NUM_W-1:0]  div_dividend;
  logic              div_done;
  logic [NUM_W-1:0]  div_quotient;
  logic [DIGIT_W-1:0] div_remainder;
  logic              ram_we;
  logic              ram_re;
  logic [DIGIT_W-1:0] ram_rdata;

  // Decode
  logic             in_accept;
  logic             slot_free;
  logic             radix_bad;
  logic             num_min;
  logic             num_zero;
  logic             negative;
  logic             is_hex;
  logic [NUM_W-1:0] magnitude;
  logic [CNT_W-1:0] count_inc;
  logic             more_digits;

  assign in_accept = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    radix_bad   = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
    num_min     = (number_r == {1'b1, {(NUM_W - 1){1'b0}}});
    num_zero    = (number_r == '0);
    negative    = number_r[NUM_W-1];
    is_hex      = (radix_r == RADIX_HEX);
    magnitude   = negative ? (~number_r + 1'b1) : number_r;
    count_inc   = count_r + 1'b1;
    more_digits = (div_quotient != '0) && (count_inc < CNT_W'(DIGIT_DEPTH));
  end

  // Next state and bookkeeping
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (radix_bad || num_min || num_zero) begin
          if (slot_free) begin
            state_nxt = S_IDLE;
          end
        end else begin
          count_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          count_nxt = count_inc;
          idx_nxt   = count_r[ADDR_W-1:0];
          if (!more_digits) begin
            if (is_hex) begin
              state_nxt = S_PFX0;
            end else if (negative) begin
              state_nxt = S_SIGN;
            end else begin
              state_nxt = S_RDREQ;
            end
          end
        end
      end
      S_PFX0: begin
        if (slot_free) begin
          state_nxt = S_PFXX;
        end
      end
      S_PFXX: begin
        if (slot_free) begin
          state_nxt = negative ? S_SIGN : S_RDREQ;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          state_nxt = S_RDREQ;
        end
      end
      S_RDREQ: begin
        state_nxt = S_DIGIT;
      end
      S_DIGIT: begin
        if (slot_free) begin
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_RDREQ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready    = 1'b0;
    out_load     = 1'b0;
    out_char     = CHAR_NUL;
    out_last     = 1'b0;
    out_err      = 1'b0;
    div_start    = 1'b0;
    div_dividend = magnitude;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_CHECK: begin
        if (radix_bad || num_min) begin
          out_load = slot_free;
          out_last = 1'b1;
          out_err  = 1'b1;
        end else if (num_zero) begin
          out_load = slot_free;
          out_char = CHAR_ZERO;
          out_last = 1'b1;
        end else begin
          div_start = 1'b1;
        end
      end
      S_DIV: begin
        // Write the remainder as the next digit; divide the quotient again while more digits remain
        if (div_done) begin
          ram_we       = 1'b1;
          div_start    = more_digits;
          div_dividend = div_quotient;
        end
      end
      S_PFX0: begin
        out_load = slot_free;
        out_char = CHAR_ZERO;
      end
      S_PFXX: begin
        out_load = slot_free;
        out_char = CHAR_X;
      end
      S_SIGN: begin
        out_load = slot_free;
        out_char = CHAR_MINUS;
      end
      S_RDREQ: begin
        ram_re = 1'b1;
      end
      S_DIGIT: begin
        out_load = slot_free;
        out_char = digit_char(ram_rdata);
        out_last = (idx_r == '0);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      number_r <= in_tdata[NUM_W-1:0];
      radix_r  <= in_tdata[NUM_W+RADIX_W-1:NUM_W];
    end
    if (out_load) begin
      out_char_r <= out_char;
      out_last_r <= out_last;
      out_err_r  <= out_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  itrs_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix_r),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Writes happen only during division and reads only during emission,
  // so no access to the same entry ever overlaps.
  itrs_digit_ram u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (div_remainder),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  `ITRS_ASSERT_NOW(a_err_is_last, out_tvalid && out_tuser, out_tlast, "error item without last")
  `ITRS_ASSERT_NOW(a_div_done_in_div, div_done, state_r == S_DIV, "divider finished outside division")
  `ITRS_ASSERT_NEXT(a_accept_to_check, in_tvalid && in_tready, state_r == S_CHECK, "accept not followed by check")
  `ITRS_ASSERT_NOW(a_digit_in_range, ram_we, count_r < CNT_W'(DIGIT_DEPTH), "digit write beyond store")

endmodule
`default_nettype wire

@@ src/itrs_digit_ram.sv @@
`default_nettype none
module itrs_digit_ram import itrs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [ADDR_W-1:0]  waddr,
  input  wire logic [DIGIT_W-1:0] wdata,
  input  wire logic               re,
  input  wire logic [ADDR_W-1:0]  raddr,
  output      logic [DIGIT_W-1:0] rdata
);

  logic [DIGIT_W-1:0] mem [DIGIT_DEPTH];
  logic [DIGIT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read request.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ src/itrs_divider.sv @@
`default_nettype none
module itrs_divider import itrs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   dividend,
  input  wire logic [RADIX_W-1:0] divisor,
  output      logic               done,
  output      logic [NUM_W-1:0]   quotient,
  output      logic [DIGIT_W-1:0] remainder
);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

  logic               busy_r;
  logic               done_r;
  logic [STEP_W-1:0]  step_r;
  logic [NUM_W-1:0]   quo_r;
  logic [REM_W-1:0]   rem_r;
  logic [RADIX_W-1:0] dsr_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] dsr_ext;
  logic             fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh  = {rem_r[REM_W-2:0], quo_r[NUM_W-1]};
    dsr_ext = {{(REM_W - RADIX_W){1'b0}}, dsr_r};
    fits    = (rem_sh >= dsr_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? (rem_sh - dsr_ext) : rem_sh;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[DIGIT_W-1:0];

endmodule
`default_nettype wire
